@@ sv/lswc_pkg.sv @@
`default_nettype none

package lswc_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_BOTTOM = 2'd2,
        REG_TOP    = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ sv/lswc_seg_if.sv @@
`default_nettype none

interface lswc_seg_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

@@ sv/lswc_clip_if.sv @@
`default_nettype none

interface lswc_clip_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         visible;
    logic signed [COORD_BITS-1:0] clipped_start_x;
    logic signed [COORD_BITS-1:0] clipped_start_y;
    logic signed [COORD_BITS-1:0] clipped_end_x;
    logic signed [COORD_BITS-1:0] clipped_end_y;

    modport source (output valid, visible, clipped_start_x, clipped_start_y,
                    clipped_end_x, clipped_end_y, input ready);
    modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                    clipped_end_x, clipped_end_y, output ready);
endinterface

`default_nettype wire

@@ sv/line_segment_window_clipper.sv @@
// Channel   Direction  Payload
// -------   ---------  -------------------------------------------------------
// seg       in         start_x, start_y, end_x, end_y
// clip      out        visible, clipped_start_x/_y, clipped_end_x/_y
// cfg_*     in         write enable, register index, window coordinate
//
// One item per cycle sustained while clip.ready keeps the output moving; the stages
// are one setup stage, one restoring-division step per stage over FRAC_BITS stages,
// then combine, multiply and interpolate stages.
// rst_n clears the valid bits and the window registers to zero.
// Each stage holds when its successor is full and stalled, so bubbles are filled
// while the output waits and nothing is lost or repeated.
`default_nettype none

module line_segment_window_clipper #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lswc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [COORD_BITS-1:0]             cfg_wdata,
    lswc_seg_if.sink                               seg,
    lswc_clip_if.source                            clip
);
    import lswc_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int W2  = CB + 2;
    localparam int UW  = FB + 1;
    localparam int PW  = UW + CB;
    localparam int NS  = FB + 4;
    localparam int S_CMB  = FB + 1;
    localparam int S_PROD = FB + 2;
    localparam int S_OUT  = FB + 3;
    localparam logic [UW-1:0] UONE = {1'b1, {FB{1'b0}}};

    typedef struct packed {
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
        logic signed [CB:0]   dx;
        logic signed [CB:0]   dy;
        logic                 rej;
        logic                 ex_zero;
        logic                 ex_one;
        logic                 lx_one;
        logic                 ey_zero;
        logic                 ey_one;
        logic                 ly_one;
    } geo_t;

    typedef struct packed {
        logic [CB-1:0] d;
        logic [CB-1:0] r;
        logic [FB-1:0] q;
    } div_t;

    typedef struct packed {
        logic                 ok;
        logic [UW-1:0]        u1;
        logic [UW-1:0]        u2;
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
        logic signed [CB:0]   dx;
        logic signed [CB:0]   dy;
    } cmb_t;

    typedef struct packed {
        logic                 ok;
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
        logic                 nx;
        logic                 ny;
        logic [PW-1:0]        m_sx;
        logic [PW-1:0]        m_sy;
        logic [PW-1:0]        m_ex;
        logic [PW-1:0]        m_ey;
    } prod_t;

    typedef struct packed {
        logic                 visible;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
    } out_t;

    // One restoring-division step.
    function automatic div_t div_step(div_t s);
        logic [CB:0] r2;
        logic        qb;
        div_t        o;
        r2 = {s.r, 1'b0};
        qb = 1'b0;
        if (r2 >= {1'b0, s.d})
        begin
            r2 = r2 - {1'b0, s.d};
            qb = 1'b1;
        end
        o.d = s.d;
        o.r = r2[CB-1:0];
        o.q = {s.q[FB-2:0], qb};
        return o;
    endfunction

    // base + u*delta truncated toward zero; m is u*|delta|.
    function automatic logic [CB-1:0] interp(logic signed [CB-1:0] base, logic neg,
                                             logic [PW-1:0] m);
        logic signed [W2-1:0] whole;
        logic signed [W2-1:0] b;
        logic                 frac;
        whole = $signed({1'b0, m[PW-1:FB]});
        frac  = |m[FB-1:0];
        if (!neg)
        begin
            b = W2'(base) + whole;
            if (b[W2-1] && frac)
                b = b + W2'(1);
        end
        else
        begin
            b = W2'(base) - whole;
            if (!b[W2-1] && (b != '0) && frac)
                b = b - W2'(1);
        end
        return b[CB-1:0];
    endfunction

    // Window registers.
    logic signed [CB-1:0] left_reg, right_reg, bottom_reg, top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            top_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_LEFT:   left_reg   <= cfg_wdata;
                REG_RIGHT:  right_reg  <= cfg_wdata;
                REG_BOTTOM: bottom_reg <= cfg_wdata;
                REG_TOP:    top_reg    <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Stage valid bits and the ready chain.
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || clip.ready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign seg.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= seg.valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // Setup: per axis the entering and leaving numerators over |delta|.
    logic signed [W2-1:0] dxw, dyw, dmx, dmy;
    logic signed [W2-1:0] nen_x, nlv_x, nen_y, nlv_y;
    logic                 dx_pos, dy_pos, dx_zero, dy_zero;
    geo_t                 geo_next;
    div_t [3:0]           div_next;

    always_comb
    begin
        dxw     = W2'(seg.end_x) - W2'(seg.start_x);
        dyw     = W2'(seg.end_y) - W2'(seg.start_y);
        dx_zero = (dxw == '0);
        dy_zero = (dyw == '0);
        dx_pos  = !dxw[W2-1] && !dx_zero;
        dy_pos  = !dyw[W2-1] && !dy_zero;
        dmx     = dxw[W2-1] ? -dxw : dxw;
        dmy     = dyw[W2-1] ? -dyw : dyw;
        nen_x   = dx_pos ? W2'(left_reg) - W2'(seg.start_x)
                         : W2'(seg.start_x) - W2'(right_reg);
        nlv_x   = dx_pos ? W2'(right_reg) - W2'(seg.start_x)
                         : W2'(seg.start_x) - W2'(left_reg);
        nen_y   = dy_pos ? W2'(bottom_reg) - W2'(seg.start_y)
                         : W2'(seg.start_y) - W2'(top_reg);
        nlv_y   = dy_pos ? W2'(top_reg) - W2'(seg.start_y)
                         : W2'(seg.start_y) - W2'(bottom_reg);

        geo_next.x1 = seg.start_x;
        geo_next.y1 = seg.start_y;
        geo_next.dx = dxw[CB:0];
        geo_next.dy = dyw[CB:0];
        geo_next.rej =
            (dx_zero ? (seg.start_x < left_reg || seg.start_x > right_reg)
                     : (nen_x > dmx || nlv_x[W2-1])) ||
            (dy_zero ? (seg.start_y < bottom_reg || seg.start_y > top_reg)
                     : (nen_y > dmy || nlv_y[W2-1]));
        geo_next.ex_zero = dx_zero || nen_x[W2-1] || (nen_x == '0);
        geo_next.ex_one  = !dx_zero && (nen_x == dmx);
        geo_next.lx_one  = dx_zero || (nlv_x >= dmx);
        geo_next.ey_zero = dy_zero || nen_y[W2-1] || (nen_y == '0);
        geo_next.ey_one  = !dy_zero && (nen_y == dmy);
        geo_next.ly_one  = dy_zero || (nlv_y >= dmy);

        div_next[0] = '{d: dmx[CB-1:0], r: nen_x[CB-1:0], q: '0};
        div_next[1] = '{d: dmx[CB-1:0], r: nlv_x[CB-1:0], q: '0};
        div_next[2] = '{d: dmy[CB-1:0], r: nen_y[CB-1:0], q: '0};
        div_next[3] = '{d: dmy[CB-1:0], r: nlv_y[CB-1:0], q: '0};
    end

    geo_t       geo_reg [0:FB];
    div_t [3:0] div_reg [0:FB];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            geo_reg[0] <= geo_next;
            div_reg[0] <= div_next;
        end
    end

    for (genvar k = 1; k <= FB; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                geo_reg[k] <= geo_reg[k-1];
                for (int j = 0; j < 4; j++)
                    div_reg[k][j] <= div_step(div_reg[k-1][j]);
            end
        end
    end

    // Combine: u1 is the largest entering ratio, u2 the smallest leaving one.
    logic [UW-1:0] fex, flx, fey, fly;
    cmb_t          cmb_next, cmb_reg;

    always_comb
    begin
        fex = geo_reg[FB].ex_zero ? '0 :
              geo_reg[FB].ex_one ? UONE : {1'b0, div_reg[FB][0].q};
        flx = geo_reg[FB].lx_one ? UONE : {1'b0, div_reg[FB][1].q};
        fey = geo_reg[FB].ey_zero ? '0 :
              geo_reg[FB].ey_one ? UONE : {1'b0, div_reg[FB][2].q};
        fly = geo_reg[FB].ly_one ? UONE : {1'b0, div_reg[FB][3].q};
        cmb_next.u1 = (fex > fey) ? fex : fey;
        cmb_next.u2 = (flx < fly) ? flx : fly;
        cmb_next.ok = !geo_reg[FB].rej && (cmb_next.u1 <= cmb_next.u2);
        cmb_next.x1 = geo_reg[FB].x1;
        cmb_next.y1 = geo_reg[FB].y1;
        cmb_next.dx = geo_reg[FB].dx;
        cmb_next.dy = geo_reg[FB].dy;
    end

    always_ff @(posedge clk)
    begin
        if (en[S_CMB])
            cmb_reg <= cmb_next;
    end

    // Products of the parameters with the delta magnitudes.
    logic [CB:0] magx, magy;
    prod_t       prod_next, prod_reg;

    always_comb
    begin
        magx = cmb_reg.dx[CB] ? -cmb_reg.dx : cmb_reg.dx;
        magy = cmb_reg.dy[CB] ? -cmb_reg.dy : cmb_reg.dy;
        prod_next.ok   = cmb_reg.ok;
        prod_next.x1   = cmb_reg.x1;
        prod_next.y1   = cmb_reg.y1;
        prod_next.nx   = cmb_reg.dx[CB];
        prod_next.ny   = cmb_reg.dy[CB];
        prod_next.m_sx = PW'(cmb_reg.u1) * PW'(magx[CB-1:0]);
        prod_next.m_sy = PW'(cmb_reg.u1) * PW'(magy[CB-1:0]);
        prod_next.m_ex = PW'(cmb_reg.u2) * PW'(magx[CB-1:0]);
        prod_next.m_ey = PW'(cmb_reg.u2) * PW'(magy[CB-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en[S_PROD])
            prod_reg <= prod_next;
    end

    // Interpolated endpoints; a rejected item gives all zeros.
    out_t out_next, out_reg;

    always_comb
    begin
        out_next.visible = prod_reg.ok;
        out_next.sx = '0;
        out_next.sy = '0;
        out_next.ex = '0;
        out_next.ey = '0;
        if (prod_reg.ok)
        begin
            out_next.sx = interp(prod_reg.x1, prod_reg.nx, prod_reg.m_sx);
            out_next.sy = interp(prod_reg.y1, prod_reg.ny, prod_reg.m_sy);
            out_next.ex = interp(prod_reg.x1, prod_reg.nx, prod_reg.m_ex);
            out_next.ey = interp(prod_reg.y1, prod_reg.ny, prod_reg.m_ey);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
            out_reg <= out_next;
    end

    assign clip.valid           = v_reg[NS-1];
    assign clip.visible         = out_reg.visible;
    assign clip.clipped_start_x = out_reg.sx;
    assign clip.clipped_start_y = out_reg.sy;
    assign clip.clipped_end_x   = out_reg.ex;
    assign clip.clipped_end_y   = out_reg.ey;

    // A rejected item leaves the block with all endpoints cleared.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (clip.valid && !clip.visible) |->
            (clip.clipped_start_x == '0 && clip.clipped_start_y == '0 &&
             clip.clipped_end_x == '0 && clip.clipped_end_y == '0))
        else $error("rejected item carries nonzero endpoints");

    // An item kept after combining has an ordered parameter pair.
    a_param_order: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[S_CMB] && cmb_reg.ok) |-> (cmb_reg.u1 <= cmb_reg.u2))
        else $error("entering parameter above leaving parameter");

    // With the output stage empty the whole chain can advance.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !clip.valid |-> seg.ready)
        else $error("input stalled while output stage is empty");

endmodule

`default_nettype wire

@@ test/line_segment_window_clipper_tb.sv @@
`timescale 1ns / 1ps

module line_segment_window_clipper_tb;
    import lswc_pkg::*;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int LATENCY = FB + 4;
    localparam longint UNIT = 64'd1 << FB;

    typedef struct packed {
        logic            visible;
        logic [CB-1:0]   sx;
        logic [CB-1:0]   sy;
        logic [CB-1:0]   ex;
        logic [CB-1:0]   ey;
    } clip_t;

    typedef struct {
        logic [CB-1:0] x1, y1, x2, y2;
        bit            has_exp;
        clip_t         exp_val;
    } seg_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_BITS-1:0] cfg_idx = REG_LEFT;
    logic [CB-1:0] cfg_wdata = '0;

    lswc_seg_if  #(.COORD_BITS(CB)) seg ();
    lswc_clip_if #(.COORD_BITS(CB)) clip ();

    line_segment_window_clipper #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata), .seg(seg.sink), .clip(clip.source)
    );

    longint win_left, win_right, win_bottom, win_top;
    clip_t  clip_queue[$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     visible_seen = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint frac_ratio(longint n, longint d);
        longint r, f;
        r = n;
        f = 0;
        if (n >= d)
            return UNIT;
        for (int k = 0; k < FB; k++)
        begin
            r = r << 1;
            f = f << 1;
            if (r >= d)
            begin
                r = r - d;
                f = f | 1;
            end
        end
        return f;
    endfunction

    function automatic longint lerp_coord(longint base, longint delta, longint u);
        longint mag, m, whole, b;
        bit neg, frac;
        neg = delta < 0;
        mag = neg ? -delta : delta;
        m = u * mag;
        whole = m >>> FB;
        frac = (m & (UNIT - 1)) != 0;
        if (!neg)
        begin
            b = base + whole;
            if (b < 0 && frac)
                b = b + 1;
        end
        else
        begin
            b = base - whole;
            if (b > 0 && frac)
                b = b - 1;
        end
        return b;
    endfunction

    function automatic clip_t clip_segment(logic signed [CB-1:0] ax, logic signed [CB-1:0] ay,
                                           logic signed [CB-1:0] bx, logic signed [CB-1:0] by);
        longint x1, y1, dx, dy, n, d, u1, u2, f;
        longint p[4], q[4];
        bit ok;
        clip_t res;
        x1 = ax;
        y1 = ay;
        dx = longint'(bx) - x1;
        dy = longint'(by) - y1;
        u1 = 0;
        u2 = UNIT;
        ok = 1;
        p[0] = -dx; q[0] = x1 - win_left;
        p[1] = dx;  q[1] = win_right - x1;
        p[2] = -dy; q[2] = y1 - win_bottom;
        p[3] = dy;  q[3] = win_top - y1;
        if (dx == 0 && (q[0] < 0 || q[1] < 0))
            ok = 0;
        if (dy == 0 && (q[2] < 0 || q[3] < 0))
            ok = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (ok && p[i] < 0)
            begin
                n = -q[i];
                d = -p[i];
                if (n > d)
                    ok = 0;
                else if (n > 0)
                begin
                    f = frac_ratio(n, d);
                    if (f > u2)
                        ok = 0;
                    else if (f > u1)
                        u1 = f;
                end
            end
            else if (ok && p[i] > 0)
            begin
                n = q[i];
                d = p[i];
                if (n < 0)
                    ok = 0;
                else if (n < d)
                begin
                    f = frac_ratio(n, d);
                    if (f < u1)
                        ok = 0;
                    else if (f < u2)
                        u2 = f;
                end
            end
        end
        res = '0;
        if (ok)
        begin
            res.visible = 1'b1;
            res.sx = CB'(lerp_coord(x1, dx, u1));
            res.sy = CB'(lerp_coord(y1, dy, u1));
            res.ex = CB'(lerp_coord(x1, dx, u2));
            res.ey = CB'(lerp_coord(y1, dy, u2));
        end
        return res;
    endfunction

    task automatic write_window(cfg_reg_t idx, logic [CB-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LEFT:   win_left = longint'($signed(value));
            REG_RIGHT:  win_right = longint'($signed(value));
            REG_BOTTOM: win_bottom = longint'($signed(value));
            default:    win_top = longint'($signed(value));
        endcase
    endtask

    task automatic set_window(logic [CB-1:0] l, logic [CB-1:0] r,
                              logic [CB-1:0] b, logic [CB-1:0] t);
        // The input goes idle, and the window changes only once the pipeline has drained.
        seg.valid <= 1'b0;
        while (clip_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        write_window(REG_LEFT, l);
        write_window(REG_RIGHT, r);
        write_window(REG_BOTTOM, b);
        write_window(REG_TOP, t);
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance.
    // Valid stays high on return so that items can follow back to back.
    task automatic send_segment(logic [CB-1:0] x1, logic [CB-1:0] y1,
                                logic [CB-1:0] x2, logic [CB-1:0] y2,
                                bit has_exp, clip_t exp_val);
        clip_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            seg.valid <= 1'b0;
            @(negedge clk);
        end
        seg.valid <= 1'b1;
        seg.start_x <= x1;
        seg.start_y <= y1;
        seg.end_x <= x2;
        seg.end_y <= y2;
        do
            @(posedge clk);
        while (!seg.ready);
        pred = clip_segment(x1, y1, x2, y2);
        if (has_exp && pred != exp_val)
            $display("table row disagrees with predictor: %h vs %h", exp_val, pred);
        clip_queue.push_back(has_exp ? exp_val : pred);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        clip.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        clip_t got, want;
        if (rst_n && clip.valid && clip.ready)
        begin
            got = {clip.visible, clip.clipped_start_x, clip.clipped_start_y,
                   clip.clipped_end_x, clip.clipped_end_y};
            results_seen++;
            if (got.visible)
                visible_seen++;
            if (clip_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
            end
            else
            begin
                want = clip_queue.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected vis=%0d %0d,%0d %0d,%0d",
                                  " got vis=%0d %0d,%0d %0d,%0d"},
                                 want.visible, $signed(want.sx), $signed(want.sy),
                                 $signed(want.ex), $signed(want.ey),
                                 got.visible, $signed(got.sx), $signed(got.sy),
                                 $signed(got.ex), $signed(got.ey));
                end
            end
        end
    end

    seg_row_t rows[$];

    task automatic add_row(int x1, int y1, int x2, int y2, bit h, clip_t e);
        seg_row_t r;
        r.x1 = CB'(x1); r.y1 = CB'(y1); r.x2 = CB'(x2); r.y2 = CB'(y2);
        r.has_exp = h;
        r.exp_val = e;
        rows.push_back(r);
    endtask

    initial begin
        clip_t z;
        int phase;
        int w0, w1, h0, h1;
        logic [CB-1:0] a, b, c, d;
        z = '0;
        win_left = 0; win_right = 0; win_bottom = 0; win_top = 0;
        seg.valid = 1'b0;
        seg.start_x = '0; seg.start_y = '0; seg.end_x = '0; seg.end_y = '0;
        clip.ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset the window is the single point at the origin.
        add_row(0, 0, 0, 0, 1, {1'b1, 16'd0, 16'd0, 16'd0, 16'd0});
        add_row(1, 0, 1, 0, 1, z);
        add_row(-5, 0, 5, 0, 1, {1'b1, 16'd0, 16'd0, 16'd0, 16'd0});
        foreach (rows[i])
            send_segment(rows[i].x1, rows[i].y1, rows[i].x2, rows[i].y2,
                         rows[i].has_exp, rows[i].exp_val);
        rows.delete();

        set_window(CB'(-100), CB'(100), CB'(-50), CB'(50));
        add_row(-10, -10, 10, 10, 1, {1'b1, 16'hfff6, 16'hfff6, 16'd10, 16'd10});
        add_row(-200, 0, 200, 0, 0, z);
        add_row(0, -200, 0, 200, 0, z);
        add_row(-100, -60, -100, 60, 0, z);      // on the left edge
        add_row(101, -60, 101, 60, 1, z);         // parallel, outside
        add_row(-300, 60, 300, 60, 1, z);         // parallel above
        add_row(100, 50, 100, 50, 1, {1'b1, 16'd100, 16'd50, 16'd100, 16'd50});
        add_row(200, 200, 200, 200, 1, z);        // outside point
        add_row(-150, 0, -50, 100, 0, z);         // touches the corner once
        add_row(-32768, -32768, 32767, 32767, 0, z);
        add_row(32767, -32768, -32768, 32767, 0, z);
        add_row(32767, 32767, 32767, 32767, 1, z);
        add_row(-32768, 0, 32767, 1, 0, z);
        add_row(150, 150, 300, 300, 1, z);
        add_row(7, -3, 91, 49, 0, z);
        foreach (rows[i])
            send_segment(rows[i].x1, rows[i].y1, rows[i].x2, rows[i].y2,
                         rows[i].has_exp, rows[i].exp_val);
        rows.delete();

        // Reversed window rejects everything.
        set_window(CB'(10), CB'(-10), CB'(-10), CB'(10));
        send_segment(CB'(-20), CB'(0), CB'(20), CB'(0), 1, z);
        send_segment(CB'(0), CB'(0), CB'(0), CB'(0), 1, z);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 56 : 0;
            recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 27 : 0;
            for (int s = 0; s < 4; s++)
            begin
                case (s)
                    0: set_window(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
                    1: set_window(CB'(-5), CB'(5), CB'(-3), CB'(3));
                    default:
                    begin
                        w0 = $urandom_range(0, 65535) - 32768;
                        w1 = w0 + $urandom_range(0, 3000);
                        h0 = $urandom_range(0, 65535) - 32768;
                        h1 = h0 + $urandom_range(0, 3000);
                        if (w1 > 32767) w1 = 32767;
                        if (h1 > 32767) h1 = 32767;
                        if ($urandom_range(9) == 0)
                            set_window(CB'(w1), CB'(w0), CB'(h0), CB'(h1));
                        else
                            set_window(CB'(w0), CB'(w1), CB'(h0), CB'(h1));
                    end
                endcase
                for (int k = 0; k < 150; k++)
                begin
                    // Mostly near the window, so clipping is exercised.
                    a = ($urandom_range(3) == 0) ? CB'($urandom) :
                        CB'(win_left + $urandom_range(0, 6000) - 3000);
                    b = ($urandom_range(3) == 0) ? CB'($urandom) :
                        CB'(win_bottom + $urandom_range(0, 6000) - 3000);
                    c = ($urandom_range(7) == 0) ? a :
                        ($urandom_range(3) == 0) ? CB'($urandom) :
                        CB'(win_right + $urandom_range(0, 6000) - 3000);
                    d = ($urandom_range(7) == 0) ? b :
                        ($urandom_range(3) == 0) ? CB'($urandom) :
                        CB'(win_top + $urandom_range(0, 6000) - 3000);
                    send_segment(a, b, c, d, 0, z);
                end
            end
        end

        seg.valid <= 1'b0;
        while (clip_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        $display("checked %0d result items, %0d visible, across several windows",
                 results_seen, visible_seen);
        $display("idle mixes: sender-heavy, receiver-heavy and full rate");
        if (mismatches == 0 && clip_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ sim.f @@
sv/lswc_pkg.sv
sv/lswc_seg_if.sv
sv/lswc_clip_if.sv
sv/line_segment_window_clipper.sv
test/line_segment_window_clipper_tb.sv
